// File: hdl/key_value_map_engine_core_assert.svh
// Assertion macros for the RTL of the key-value map engine.
// Each macro expects signals named clk and arst_n in the module that uses it.
`ifndef KEY_VALUE_MAP_ENGINE_CORE_ASSERT_SVH
`define KEY_VALUE_MAP_ENGINE_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define KVME_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define KVME_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: hdl/kvme_pkg.sv
`default_nettype none

package kvme_pkg;

	// Number of slots in the store.
	localparam int ENTRIES = 128;
	localparam int IDX_W   = $clog2(ENTRIES);
	localparam int CNT_W   = $clog2(ENTRIES + 1);

	localparam int KEY_W   = 64;
	localparam int VAL_W   = 64;
	localparam int OCNT_W  = 8;

	typedef enum logic [1:0] {
		KIND_INSERT = 2'd0,
		KIND_FIND   = 2'd1,
		KIND_REMOVE = 2'd2,
		KIND_CLEAR  = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_MISS = 2'd1,
		ST_FULL = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE   = 2'd0,
		S_SCAN   = 2'd1,
		S_COMMIT = 2'd2
	} state_t;

	typedef struct packed {
		kind_t              kind;
		logic [KEY_W-1:0]   key;
		logic [VAL_W-1:0]   value;
	} req_item_t;

	typedef struct packed {
		status_t            status;
		logic [VAL_W-1:0]   found_value;
		logic [OCNT_W-1:0]  entry_count;
	} rsp_item_t;

endpackage

`default_nettype wire

// File: hdl/key_value_map_engine_core.sv
`default_nettype none

// Key-value map engine: a fixed store of ENTRIES (128) slots mapping 64-bit keys to 64-bit
// values, driven by insert, find, remove and clear-all requests, each of which gives exactly
// one response item carrying a status, the value found or removed (zero otherwise) and the
// entry count after the request. For an insert, find or remove the block walks every slot
// once, issuing one read a cycle to the key and value memories, compares each key against
// the request in one shared 64-bit comparator in the cycle after its read and notes the
// first free slot on the way, then commits the change in the commit step. The block is ready
// again as soon as the response is registered. A clear-all goes from acceptance straight to
// the commit step, since the slot occupancy flags are flip-flops that reset and clear all at
// once; the key and value memories are never cleared and need no clearing pass after reset.
// One request is in flight at a time, but the response sits in its own output register, so
// the next request may be accepted while the previous response still waits to be taken. The
// commit step waits while that register is still full, so a receiver that holds off adds its
// hold-off to the latency of the next item.

`include "key_value_map_engine_core_assert.svh"

module key_value_map_engine_core
	import kvme_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      req_valid,
	output logic           req_ready,
	input  wire req_item_t req,
	output logic           rsp_valid,
	input  wire logic      rsp_ready,
	output rsp_item_t      rsp
);

	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(ENTRIES);

	// Sequencer state.
	state_t state_q, state_d;

	// The request being served.
	req_item_t op_q;

	// Slot occupancy flags and the live entry count.
	logic [ENTRIES-1:0] used_q;
	logic [CNT_W-1:0]   count_q;

	// Slot memories.
	logic [KEY_W-1:0] key_mem [ENTRIES];
	logic [VAL_W-1:0] val_mem [ENTRIES];
	logic [KEY_W-1:0] key_rd_q;
	logic [VAL_W-1:0] val_rd_q;

	// Scan address counter and the stage that lines up with the memory read data.
	logic [CNT_W-1:0] scan_cnt_q;
	logic [IDX_W-1:0] rd_addr;
	logic             issue;
	logic             vld_s1;
	logic [IDX_W-1:0] idx_s1;
	logic             used_s1;

	// What the scan has found so far.
	logic             hit_q;
	logic [IDX_W-1:0] hit_idx_q;
	logic [VAL_W-1:0] hit_val_q;
	logic             free_q;
	logic [IDX_W-1:0] free_idx_q;

	// Response register.
	logic      rsp_valid_q;
	rsp_item_t rsp_q;

	// Commit decode.
	logic             do_commit;
	logic             key_match;
	status_t          cm_status;
	logic [VAL_W-1:0] cm_found;
	logic [CNT_W-1:0] cm_count;
	logic             cm_ins;
	logic             cm_rem;
	logic             cm_clr;

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;
	assign rd_addr   = scan_cnt_q[IDX_W-1:0];
	assign issue     = (state_q == S_SCAN) && (scan_cnt_q < FULL_CNT);
	assign key_match = used_s1 && (key_rd_q == op_q.key);

	// The sequencer: accept in idle, walk the slots, then commit once the response
	// register is free to take the result.
	always_comb begin
		state_d   = state_q;
		req_ready = 1'b0;
		do_commit = 1'b0;
		case (state_q)
			S_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					if (req.kind == KIND_CLEAR) begin
						state_d = S_COMMIT;
					end else begin
						state_d = S_SCAN;
					end
				end
			end
			S_SCAN: begin
				if (vld_s1 && (idx_s1 == LAST_IDX)) begin
					state_d = S_COMMIT;
				end
			end
			S_COMMIT: begin
				if (!rsp_valid_q || rsp_ready) begin
					do_commit = 1'b1;
					state_d   = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Outcome of the request, from the scan results. A duplicate insert is
	// reported before a full store is considered.
	always_comb begin
		cm_status = ST_OK;
		cm_found  = '0;
		cm_count  = count_q;
		cm_ins    = 1'b0;
		cm_rem    = 1'b0;
		cm_clr    = 1'b0;
		case (op_q.kind)
			KIND_INSERT: begin
				if (hit_q) begin
					cm_status = ST_MISS;
				end else if (!free_q) begin
					cm_status = ST_FULL;
				end else begin
					cm_ins   = 1'b1;
					cm_count = count_q + CNT_W'(1);
				end
			end
			KIND_FIND: begin
				if (hit_q) begin
					cm_found = hit_val_q;
				end else begin
					cm_status = ST_MISS;
				end
			end
			KIND_REMOVE: begin
				if (hit_q) begin
					cm_found = hit_val_q;
					cm_rem   = 1'b1;
					if (count_q != '0) begin
						cm_count = count_q - CNT_W'(1);
					end
				end else begin
					cm_status = ST_MISS;
				end
			end
			KIND_CLEAR: begin
				cm_clr   = 1'b1;
				cm_count = '0;
			end
			default: begin
				cm_status = ST_OK;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Control registers of the scan, the store and the response.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q      <= '0;
			count_q     <= '0;
			scan_cnt_q  <= '0;
			vld_s1      <= 1'b0;
			hit_q       <= 1'b0;
			free_q      <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (req_valid && req_ready) begin
				scan_cnt_q <= '0;
				hit_q      <= 1'b0;
				free_q     <= 1'b0;
			end
			if (issue) begin
				scan_cnt_q <= scan_cnt_q + CNT_W'(1);
			end
			vld_s1 <= issue;
			if (vld_s1) begin
				if (key_match) begin
					hit_q <= 1'b1;
				end
				if (!used_s1) begin
					free_q <= 1'b1;
				end
			end
			if (rsp_valid_q && rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			if (do_commit) begin
				rsp_valid_q <= 1'b1;
				count_q     <= cm_count;
				if (cm_clr) begin
					used_q <= '0;
				end else if (cm_ins) begin
					used_q[free_idx_q] <= 1'b1;
				end else if (cm_rem) begin
					used_q[hit_idx_q] <= 1'b0;
				end
			end
		end
	end

	// Payload registers. Only the first match and the lowest free slot are kept;
	// a key never sits in more than one slot.
	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			op_q <= req;
		end
		if (issue) begin
			idx_s1  <= rd_addr;
			used_s1 <= used_q[rd_addr];
		end
		if (vld_s1 && key_match && !hit_q) begin
			hit_idx_q <= idx_s1;
			hit_val_q <= val_rd_q;
		end
		if (vld_s1 && !used_s1 && !free_q) begin
			free_idx_q <= idx_s1;
		end
		if (do_commit) begin
			rsp_q.status      <= cm_status;
			rsp_q.found_value <= cm_found;
			rsp_q.entry_count <= OCNT_W'(cm_count);
		end
	end

	// Slot memories: one write port used at commit, one read port used by the scan.
	always_ff @(posedge clk) begin
		if (do_commit && cm_ins) begin
			key_mem[free_idx_q] <= op_q.key;
			val_mem[free_idx_q] <= op_q.value;
		end
		key_rd_q <= key_mem[rd_addr];
		val_rd_q <= val_mem[rd_addr];
	end

	`KVME_ASSERT_SAME(a_count_tracks_flags, 1'b1, $countones(used_q) == count_q,
		"entry count differs from the number of occupied slots")
	`KVME_ASSERT_SAME(a_full_only_when_full,
		(state_q == S_COMMIT) && (op_q.kind == KIND_INSERT) && !hit_q && !free_q,
		count_q == FULL_CNT, "insert refused as full while a slot is free")
	`KVME_ASSERT_SAME(a_hit_slot_occupied, (state_q == S_SCAN) && hit_q,
		used_q[hit_idx_q], "matched slot is not occupied")
	`KVME_ASSERT_SAME(a_rsp_from_commit, $rose(rsp_valid_q),
		$past(state_q) == S_COMMIT, "response raised outside the commit step")

endmodule

`default_nettype wire
